FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// Tagged stack package
// Shared sizes, codes and types of the tagged stack.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int DEPTH = 256;                      // number of stack cells
	localparam int CNT_W = $clog2(DEPTH + 1);        // fill count, 0..DEPTH
	localparam int CAP_W = 9;                        // capacity register
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int DATA_W = 8;

	typedef enum logic [1:0] {
		CMD_PUSH_DATA = 2'd0,
		CMD_POP_DATA  = 2'd1,
		CMD_PUSH_MARK = 2'd2,
		CMD_POP_MARK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_MISMATCH  = 2'd3
	} status_t;

	// register index of capacity
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic              mark;
		logic [DATA_W-1:0] data;
	} entry_t;

	// shift control broadcast to every cell
	typedef struct packed {
		logic push;   // take the entry of the cell above
		logic pop;    // take the entry of the cell below
	} shift_t;

endpackage

FILE: rtl/tsm_cell.sv
// ----------------------------------------------------------------------------
// Tagged stack cell
// One stack entry; shifts toward the bottom on push, toward the top on pop.
// ----------------------------------------------------------------------------
module tsm_cell
	import tsm_pkg::*;
(
	input  logic   clk,
	input  shift_t ctl,
	input  entry_t upper,   // neighbor nearer the top (new entry for cell 0)
	input  entry_t lower,   // neighbor nearer the bottom
	output entry_t ent
);

	entry_t ent_q;

	// payload only, no reset: cells above the fill count are never read
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ent_q <= upper;
		end else if (ctl.pop) begin
			ent_q <= lower;
		end
	end

	assign ent = ent_q;

endmodule

FILE: rtl/tagged_stack_with_marks.sv
// ----------------------------------------------------------------------------
// Tagged byte stack with jump marks
// A result word appears in the cycle after its command word is taken.
// One command per cycle while no result waits on the output; the top entry sits in cell 0 of the chain.
// Reset: fill count zero, capacity 256, output empty; cell contents undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tagged_stack_with_marks
	import tsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	// command stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,    // [7:0] push_value
	input  logic [1:0]        s_tuser,    // [1:0] cmd

	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,    // [7:0] pop_value
	output logic [1:0]        m_tuser,    // [1:0] status

	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// ---- configuration -----------------------------------------------------
	logic [CAP_W-1:0] capacity_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(256);
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : 32'd0;

	// ---- command decode ----------------------------------------------------
	logic             acc;
	cmd_t             cmd;
	logic [CNT_W-1:0] count_q;
	entry_t           cell_ent [DEPTH];
	entry_t           top;
	entry_t           new_ent;
	logic             room;       // count below min(capacity, DEPTH)
	logic             empty;
	shift_t           shift;
	logic [7:0]       res_val;
	status_t          res_st;

	// output register splits the two sides: take a word when no result waits or the waiting one leaves
	assign s_tready = !m_tvalid || m_tready;
	assign acc      = s_tvalid & s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign top      = cell_ent[0];
	assign empty    = (count_q == '0);
	assign room     = (CMP_W'(count_q) < CMP_W'(capacity_q))
	               && (CMP_W'(count_q) < CMP_W'(DEPTH));

	always_comb begin
		shift   = '0;
		new_ent = '0;
		res_val = '0;
		res_st  = ST_OK;
		unique case (cmd)
			CMD_PUSH_DATA: begin
				new_ent.data = s_tdata;
				shift.push   = room;
				res_st       = room ? ST_OK : ST_OVERFLOW;
			end
			CMD_PUSH_MARK: begin
				new_ent.mark = 1'b1;
				shift.push   = room;
				res_st       = room ? ST_OK : ST_OVERFLOW;
			end
			CMD_POP_DATA: begin
				// wrong tag still drops the entry
				shift.pop = !empty;
				if (empty) begin
					res_st = ST_UNDERFLOW;
				end else if (top.mark) begin
					res_st = ST_MISMATCH;
				end else begin
					res_val = top.data;
				end
			end
			CMD_POP_MARK: begin
				shift.pop = !empty;
				if (empty) begin
					res_st = ST_UNDERFLOW;
				end else if (!top.mark) begin
					res_st = ST_MISMATCH;
				end
			end
			default: begin
				res_st = ST_OK;
			end
		endcase
		if (!acc) begin
			shift = '0;
		end
	end

	// ---- fill count --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift.push) begin
			count_q <= count_q + 1'b1;
		end else if (shift.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// ---- cell chain: cell 0 is the top of stack ----------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t up_ent;
		entry_t lo_ent;
		if (i == 0) begin : g_first
			assign up_ent = new_ent;
		end else begin : g_mid_up
			assign up_ent = cell_ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign lo_ent = '0;
		end else begin : g_mid_lo
			assign lo_ent = cell_ent[i+1];
		end
		tsm_cell u_cell (
			.clk   (clk),
			.ctl   (shift),
			.upper (up_ent),
			.lower (lo_ent),
			.ent   (cell_ent[i])
		);
	end

	// ---- result register ---------------------------------------------------
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	status_t    m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_tdata_q <= res_val;
			m_tuser_q <= res_st;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// ---- checks ------------------------------------------------------------
	`ASSERT_ALW(a_count_bound, clk, (CMP_W'(count_q) <= CMP_W'(DEPTH)), "fill count above depth")
	`ASSERT_RST(a_push_counts, clk, arst_n, (shift.push |=> count_q == $past(count_q) + 1'b1), "push lost in count")
	`ASSERT_RST(a_acc_result, clk, arst_n, (acc |=> m_tvalid), "accepted word gave no result")
	`ASSERT_RST(a_underflow, clk, arst_n, ((acc && empty && (cmd == CMD_POP_DATA || cmd == CMD_POP_MARK)) |=> (m_tuser_q == ST_UNDERFLOW && count_q == '0)), "empty pop not flagged")

endmodule
